// ----- hw/rtl/bsbcs_pkg.sv -----
// Package for the subframe BCH(15,11) check and strip core.
// Holds the GF(16) power table, the codeword check function and the result type.
// No dependencies.
package bsbcs_pkg;

  localparam int unsigned WordsPerSubframeDef = 10;
  localparam int unsigned NavWordW            = 32;
  localparam int unsigned DataBitsW           = 26;
  localparam int unsigned DataLenW            = 5;
  localparam int unsigned WordNumW            = 4;
  localparam int unsigned CodewordW           = 15;

  localparam logic [DataLenW-1:0] LenFirst = DataLenW'(26);
  localparam logic [DataLenW-1:0] LenOther = DataLenW'(22);

  typedef struct packed {
    logic [DataBitsW-1:0] data_bits;
    logic [DataLenW-1:0]  data_len;
    logic [WordNumW-1:0]  word_number;
    logic                 word_ok;
    logic                 subframe_ok;
    logic                 last;
  } result_t;

  function automatic logic [3:0] gf16_pow(input int unsigned e);
    logic [3:0] val;
    unique case (e)
      0:       val = 4'd1;
      1:       val = 4'd2;
      2:       val = 4'd4;
      3:       val = 4'd8;
      4:       val = 4'd3;
      5:       val = 4'd6;
      6:       val = 4'd12;
      7:       val = 4'd11;
      8:       val = 4'd5;
      9:       val = 4'd10;
      10:      val = 4'd7;
      11:      val = 4'd14;
      12:      val = 4'd15;
      13:      val = 4'd13;
      default: val = 4'd9;
    endcase
    return val;
  endfunction

  // Both syndromes are plain XOR sums of constant table entries selected by codeword bits.
  function automatic logic cw_ok(input logic [CodewordW-1:0] cw);
    logic [3:0] s1;
    logic [3:0] s2;
    s1 = '0;
    s2 = '0;
    for (int unsigned k = 0; k < CodewordW; k++) begin
      if (cw[k]) begin
        s1 = s1 ^ gf16_pow(k % 15);
        s2 = s2 ^ gf16_pow((2 * k) % 15);
      end
    end
    return (s1 == 4'd0) && (s2 == 4'd0);
  endfunction

endpackage

// ----- hw/rtl/beidou_subframe_bch_check_strip_core.sv -----
// Top level of the subframe BCH(15,11) check and parity strip core.
// Depends on bsbcs_pkg for the check function, constants and the result type.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | nav_word_i, first_word_i
// out     | output    | out_valid_o/out_ready_i | data_bits_o .. last_o
//
// Each beat is checked when accepted; its result is registered in the output or skid register.
// One beat per cycle while out_ready_i is high; a skid register holds a second stalled result.
// Input ready drops only while both the output and the skid register hold results.
// Reset clears the word count, the sticky error flag and both valid flags.
module beidou_subframe_bch_check_strip_core #(
  parameter int unsigned WORDS_PER_SUBFRAME = bsbcs_pkg::WordsPerSubframeDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bsbcs_pkg::NavWordW-1:0]    nav_word_i,
  input  logic                              first_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bsbcs_pkg::DataBitsW-1:0]   data_bits_o,
  output logic [bsbcs_pkg::DataLenW-1:0]    data_len_o,
  output logic [bsbcs_pkg::WordNumW-1:0]    word_number_o,
  output logic                              word_ok_o,
  output logic                              subframe_ok_o,
  output logic                              last_o
);
  import bsbcs_pkg::*;

  localparam logic [WordNumW-1:0] WordsLimit = WordNumW'(WORDS_PER_SUBFRAME);
  localparam logic [WordNumW-1:0] LastWord   = WordNumW'(WORDS_PER_SUBFRAME - 1);

  logic [WordNumW-1:0] word_count_q, word_count_d;
  logic                sub_err_q, sub_err_d;
  logic                out_valid_q, skid_valid_q;
  result_t             out_q, skid_q;
  result_t             res;
  logic                accept;
  logic                take;
  logic [WordNumW-1:0] num;
  logic                ok;
  logic                err_base;

  assign accept = in_valid_i && in_ready_o;
  assign take   = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    num = word_count_q;
    if (first_word_i || (word_count_q >= WordsLimit)) begin
      num = '0;
    end
    err_base = (num == '0) ? 1'b0 : sub_err_q;
    if (num == '0) begin
      ok = cw_ok(nav_word_i[14:0]);
      res.data_bits = nav_word_i[29:4];
      res.data_len  = LenFirst;
    end else begin
      ok = cw_ok({nav_word_i[29:19], nav_word_i[7:4]}) &&
           cw_ok({nav_word_i[18:8], nav_word_i[3:0]});
      res.data_bits = {4'b0000, nav_word_i[29:8]};
      res.data_len  = LenOther;
    end
    sub_err_d = err_base || !ok;
    res.word_number = num;
    res.word_ok     = ok;
    res.subframe_ok = !sub_err_d;
    res.last        = (num == LastWord);
    word_count_d    = res.last ? '0 : num + WordNumW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      sub_err_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        word_count_q <= word_count_d;
        sub_err_q    <= sub_err_d;
      end
      if (!out_valid_q || take) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_bits_o   = out_q.data_bits;
  assign data_len_o    = out_q.data_len;
  assign word_number_o = out_q.word_number;
  assign word_ok_o     = out_q.word_ok;
  assign subframe_ok_o = out_q.subframe_ok;
  assign last_o        = out_q.last;

endmodule
